[rtl/aee_pkg.sv]
package aee_pkg;

   localparam int ENERGY_W      = 16;  // Q8.8 energy / level / background on the channels
   localparam int EST_W         = 24;  // Q8.16 internal estimates
   localparam int FRAC_SHIFT    = EST_W - ENERGY_W;
   localparam int COUNT_W       = 4;
   localparam int WARMUP_FRAMES = 10;  // 1 .. 15

   localparam int RISE_W   = 16;
   localparam int WEIGHT_W = 8;
   localparam int THRESH_W = 15;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [RISE_W-1:0]   RISE_RESET   = 16'd3277;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd1;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd2560;

   // Divider geometry: quotient is one biased estimate, divisor is 2*(n+1)
   localparam int DIV_W       = WEIGHT_W + 1;        // n+1, up to 256
   localparam int DVS_W       = DIV_W + 1;           // 2*(n+1)
   localparam int PROD_W      = EST_W + RISE_W;
   localparam int AVG_PROD_W  = EST_W + WEIGHT_W;
   localparam int NUM_W       = AVG_PROD_W + 2;      // 2*(sum) + d
   localparam int DIV_BITS    = 3;                   // quotient bits per cycle
   localparam int DIV_ITERS   = EST_W / DIV_BITS;
   localparam int ITER_W      = $clog2(DIV_ITERS);
   localparam int PC_W        = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RISE_FRACTION    = 2'd0,
      CSR_FORGET_WEIGHT    = 2'd1,
      CSR_SPEECH_THRESHOLD = 2'd2,
      CSR_UNUSED           = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_WAIT,         // take a request
      OP_MUL_WARM,     // biased background * count, divisor count+1
      OP_SPEECH_RISE,  // speech decision, difference * rise fraction
      OP_BG_RISE,      // next background after warm-up
      OP_MUL_LEVEL,    // biased level * weight, divisor weight+1
      OP_FIRST,        // first frame of an utterance
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_WRITEBACK,
      OP_EMIT
   } uop_type;

   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_COUNT_ZERO,
      C_WARM_DONE,
      C_DIV_BUSY,
      C_RSP_BUSY
   } ucond_type;

   typedef struct packed {
      uop_type           op;
      ucond_type         cond;
      logic [PC_W-1:0]   target;
   } ucode_type;

   localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
   localparam logic [PC_W-1:0] PC_RISE   = 4'd4;
   localparam logic [PC_W-1:0] PC_DLOAD  = 4'd7;
   localparam logic [PC_W-1:0] PC_DSTEP  = 4'd8;
   localparam logic [PC_W-1:0] PC_FIRST  = 4'd11;
   localparam logic [PC_W-1:0] PC_EMIT   = 4'd15;

   // Falling through goes to the next step; the last step wraps to idle.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      unique case (pc)
         4'd0:    w = '{op: OP_WAIT,        cond: C_NO_REQ,     target: PC_IDLE};
         4'd1:    w = '{op: OP_NOP,         cond: C_COUNT_ZERO, target: PC_FIRST};
         4'd2:    w = '{op: OP_NOP,         cond: C_WARM_DONE,  target: PC_RISE};
         4'd3:    w = '{op: OP_MUL_WARM,    cond: C_ALWAYS,     target: PC_DLOAD};
         4'd4:    w = '{op: OP_SPEECH_RISE, cond: C_NEVER,      target: PC_IDLE};
         4'd5:    w = '{op: OP_BG_RISE,     cond: C_NEVER,      target: PC_IDLE};
         4'd6:    w = '{op: OP_MUL_LEVEL,   cond: C_NEVER,      target: PC_IDLE};
         4'd7:    w = '{op: OP_DIV_LOAD,    cond: C_NEVER,      target: PC_IDLE};
         4'd8:    w = '{op: OP_DIV_STEP,    cond: C_DIV_BUSY,   target: PC_DSTEP};
         4'd9:    w = '{op: OP_WRITEBACK,   cond: C_ALWAYS,     target: PC_EMIT};
         4'd11:   w = '{op: OP_FIRST,       cond: C_ALWAYS,     target: PC_EMIT};
         4'd15:   w = '{op: OP_EMIT,        cond: C_RSP_BUSY,   target: PC_EMIT};
         default: w = '{op: OP_NOP,         cond: C_ALWAYS,     target: PC_IDLE};
      endcase
      return w;
   endfunction

endpackage

[rtl/aee_req_if.sv]
interface aee_req_if
   import aee_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [ENERGY_W-1:0] frame_energy;
   logic                       restart;

   modport source (output valid, output frame_energy, output restart, input ready);
   modport sink   (input valid, input frame_energy, input restart, output ready);
endinterface

[rtl/aee_rsp_if.sv]
interface aee_rsp_if
   import aee_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic                       is_speech;
   logic signed [ENERGY_W-1:0] level_out;
   logic signed [ENERGY_W-1:0] background_out;

   modport source (output valid, output is_speech, output level_out, output background_out,
                   input ready);
   modport sink   (input valid, input is_speech, input level_out, input background_out,
                   output ready);
endinterface

[rtl/adaptive_energy_endpointer_top.sv]
// Channel   Dir  Handshake            Payload
// req_ch    in   valid/ready          frame_energy[15:0] s Q8.8, restart
// rsp_ch    out  valid/ready          is_speech, level_out[15:0], background_out[15:0]
// csr_*     in   csr_wen (no wait)    csr_index[1:0], csr_wdata[15:0]
//
// One request at a time. After acceptance the first-frame step runs for the first frame
// of an utterance; warm-up runs a multiply, the divide and write-back; later frames run
// the speech decision, background rise, level multiply, divide and write-back. The emit
// step loads the result register. The radix-8 restoring divider forms the rounded means.
// Reset is synchronous: estimates and frame count clear, registers take defaults.
// A result waiting in the output register does not block the next request; a
// new result is held back only while the previous one has not been taken.

module adaptive_energy_endpointer_top
   import aee_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   aee_req_if.sink                req_ch,
   aee_rsp_if.source              rsp_ch,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [EST_W-1:0] SIGN_FLIP = {1'b1, {(EST_W-1){1'b0}}};

   // Configuration registers
   logic [RISE_W-1:0]   rise_ff,   rise_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;

   // Sequencer
   logic [PC_W-1:0]   pc_ff, pc_in;
   ucode_type         uword;
   logic              cond_true;

   // Block state and datapath registers
   logic signed [EST_W-1:0] bg_ff, bg_in;
   logic signed [EST_W-1:0] lv_ff, lv_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic signed [EST_W-1:0] energy_ff, energy_in;
   logic signed [EST_W-1:0] bg_next_ff, bg_next_in;
   logic                    speech_ff, speech_in;
   logic                    warm_ff, warm_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [DIV_W-1:0]        d_ff, d_in;
   logic [DVS_W-1:0]        rem_ff, rem_in;
   logic [EST_W-1:0]        quo_ff, quo_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;

   // Result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_speech_ff, rsp_speech_in;
   logic signed [ENERGY_W-1:0] rsp_level_ff, rsp_level_in;
   logic signed [ENERGY_W-1:0] rsp_bg_ff, rsp_bg_in;

   logic                    req_accept;
   logic                    rsp_busy;
   logic [EST_W-1:0]        mul_a;
   logic [RISE_W-1:0]       mul_b;

   assign uword       = ucode_rom(pc_ff);
   // hold off requests while reset is asserted
   assign req_ch.ready = (uword.op == OP_WAIT) && !reset;
   assign req_accept  = req_ch.valid && req_ch.ready;
   assign rsp_busy    = rsp_valid_ff && !rsp_ch.ready;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.is_speech      = rsp_speech_ff;
   assign rsp_ch.level_out      = rsp_level_ff;
   assign rsp_ch.background_out = rsp_bg_ff;

   // Configuration writes
   always_comb begin
      rise_in   = rise_ff;
      weight_in = weight_ff;
      thresh_in = thresh_ff;
      if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_RISE_FRACTION:    rise_in   = csr_wdata[RISE_W-1:0];
            CSR_FORGET_WEIGHT:    weight_in = csr_wdata[WEIGHT_W-1:0];
            CSR_SPEECH_THRESHOLD: thresh_in = csr_wdata[THRESH_W-1:0];
            CSR_UNUSED:           ;
         endcase
      end
   end

   // Branch conditions: a true condition jumps, else advance one step
   always_comb begin
      unique case (uword.cond)
         C_NEVER:      cond_true = 1'b0;
         C_ALWAYS:     cond_true = 1'b1;
         C_NO_REQ:     cond_true = !req_accept;
         C_COUNT_ZERO: cond_true = (count_ff == '0);
         C_WARM_DONE:  cond_true = (count_ff >= COUNT_W'(WARMUP_FRAMES));
         C_DIV_BUSY:   cond_true = (iter_ff != ITER_W'(DIV_ITERS - 1));
         C_RSP_BUSY:   cond_true = rsp_busy;
         default:      cond_true = 1'b0;
      endcase
      pc_in = cond_true ? uword.target : pc_ff + PC_W'(1);
   end

   // Shared multiplier operands; estimates go in with the sign bit flipped
   // so that the averaging divide works on unsigned values.
   always_comb begin
      mul_a = (bg_ff ^ SIGN_FLIP);
      mul_b = {{(RISE_W-COUNT_W){1'b0}}, count_ff};
      unique case (uword.op)
         OP_MUL_LEVEL: begin
            mul_a = (lv_ff ^ SIGN_FLIP);
            mul_b = {{(RISE_W-WEIGHT_W){1'b0}}, weight_ff};
         end
         OP_SPEECH_RISE: begin
            mul_a = energy_ff - bg_ff;   // nonnegative whenever it is used
            mul_b = rise_ff;
         end
         default: ;
      endcase
   end

   // Datapath, one operation per control word
   always_comb begin
      logic signed [EST_W:0]    lb_diff;
      logic signed [EST_W:0]    thresh_q;
      logic [PROD_W-1:0]        rounded;
      logic [AVG_PROD_W:0]      sum;
      logic [NUM_W-1:0]         numer;
      logic [DVS_W-1:0]         r;
      logic [EST_W-1:0]         q;
      logic signed [EST_W-1:0]  q_signed;

      bg_in         = bg_ff;
      lv_in         = lv_ff;
      count_in      = count_ff;
      energy_in     = energy_ff;
      bg_next_in    = bg_next_ff;
      speech_in     = speech_ff;
      warm_in       = warm_ff;
      prod_in       = prod_ff;
      d_in          = d_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      iter_in       = iter_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_speech_in = rsp_speech_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_bg_in     = rsp_bg_ff;

      lb_diff  = {lv_ff[EST_W-1], lv_ff} - {bg_ff[EST_W-1], bg_ff};
      thresh_q = {2'b00, thresh_ff, {FRAC_SHIFT{1'b0}}};
      rounded  = prod_ff + PROD_W'(32'h8000);
      sum      = {1'b0, prod_ff[AVG_PROD_W-1:0]} + {{(AVG_PROD_W-EST_W+1){1'b0}},
                                                     (energy_ff ^ SIGN_FLIP)};
      numer    = {sum, 1'b0} + {{(NUM_W-DIV_W){1'b0}}, d_ff};
      r        = rem_ff;
      q        = quo_ff;
      q_signed = quo_ff ^ SIGN_FLIP;

      unique case (uword.op)
         OP_WAIT: begin
            if (req_accept) begin
               energy_in = {req_ch.frame_energy, {FRAC_SHIFT{1'b0}}};
               speech_in = 1'b0;
               if (req_ch.restart) count_in = '0;
            end
         end
         OP_MUL_WARM: begin
            prod_in = mul_a * mul_b;
            d_in    = {{(DIV_W-COUNT_W){1'b0}}, count_ff} + DIV_W'(1);
            warm_in = 1'b1;
         end
         OP_SPEECH_RISE: begin
            speech_in = (lb_diff > thresh_q);
            prod_in   = mul_a * mul_b;
         end
         OP_BG_RISE: begin
            // drop at once to a lower energy, else rise by the rounded fraction
            if (energy_ff < bg_ff) bg_next_in = energy_ff;
            else bg_next_in = bg_ff + rounded[PROD_W-1:RISE_W];
         end
         OP_MUL_LEVEL: begin
            prod_in = mul_a * mul_b;
            d_in    = {1'b0, weight_ff} + DIV_W'(1);
            warm_in = 1'b0;
         end
         OP_FIRST: begin
            bg_in    = energy_ff;
            lv_in    = energy_ff;
            count_in = count_ff + COUNT_W'(1);
         end
         OP_DIV_LOAD: begin
            // round to nearest: floor((2*sum + d) / 2d)
            rem_in  = numer[NUM_W-1:EST_W];
            quo_in  = numer[EST_W-1:0];
            iter_in = '0;
         end
         OP_DIV_STEP: begin
            for (int k = 0; k < DIV_BITS; k++) begin
               r = {r[DVS_W-2:0], q[EST_W-1]};
               q = {q[EST_W-2:0], 1'b0};
               if (r >= {d_ff, 1'b0}) begin
                  r    = r - {d_ff, 1'b0};
                  q[0] = 1'b1;
               end
            end
            rem_in  = r;
            quo_in  = q;
            iter_in = iter_ff + ITER_W'(1);
         end
         OP_WRITEBACK: begin
            if (warm_ff) begin
               bg_in    = q_signed;
               lv_in    = energy_ff;
               count_in = count_ff + COUNT_W'(1);
            end else begin
               // hold the level up to the previous background
               lv_in = (q_signed < bg_ff) ? bg_ff : q_signed;
               bg_in = bg_next_ff;
            end
         end
         OP_EMIT: begin
            if (!rsp_busy) begin
               rsp_valid_in  = 1'b1;
               rsp_speech_in = speech_ff;
               rsp_level_in  = lv_ff[EST_W-1:FRAC_SHIFT];
               rsp_bg_in     = bg_ff[EST_W-1:FRAC_SHIFT];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rise_ff      <= RISE_RESET;
         weight_ff    <= WEIGHT_RESET;
         thresh_ff    <= THRESH_RESET;
         pc_ff        <= PC_IDLE;
         bg_ff        <= '0;
         lv_ff        <= '0;
         count_ff     <= '0;
         speech_ff    <= 1'b0;
         warm_ff      <= 1'b0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rise_ff      <= rise_in;
         weight_ff    <= weight_in;
         thresh_ff    <= thresh_in;
         pc_ff        <= pc_in;
         bg_ff        <= bg_in;
         lv_ff        <= lv_in;
         count_ff     <= count_in;
         speech_ff    <= speech_in;
         warm_ff      <= warm_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      energy_ff     <= energy_in;
      bg_next_ff    <= bg_next_in;
      prod_ff       <= prod_in;
      d_ff          <= d_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      rsp_speech_ff <= rsp_speech_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_bg_ff     <= rsp_bg_in;
   end

endmodule
